FILE: sv/ifps_pkg.sv
// shared types and constants of the isp flash page sequencer
package ifps_pkg;

    // largest device the sequencer addresses, in pages
    localparam int MAX_PAGES = 1024;

    localparam int SHIFT_W   = 3;
    localparam int LIMIT_W   = 11;
    localparam int WIDX_W    = 8;
    localparam int PAGE_W    = 11;
    localparam int ADDR_W    = 16;
    localparam int ADDR_SPAN = PAGE_W + (1 << SHIFT_W) - 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = LIMIT_W;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // serial programming instruction bytes
    localparam logic [7:0] OP_ERASE      = 8'hAC;
    localparam logic [7:0] OP_ERASE_ARG  = 8'h80;
    localparam logic [7:0] OP_LOAD_LOW   = 8'h40;
    localparam logic [7:0] OP_LOAD_HIGH  = 8'h48;
    localparam logic [7:0] OP_WRITE_PAGE = 8'h4C;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAGE_SHIFT = 1'b0,
        REG_PAGE_LIMIT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] page_shift;
        logic [LIMIT_W-1:0] page_limit;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_ERASE,
        CMD_OVERFLOW,
        CMD_LOAD,
        CMD_LOAD_WRITE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [WIDX_W-1:0]   widx;
        logic [7:0]          lo;
        logic [7:0]          hi;
        logic [ADDR_W-1:0]   addr;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: sv/ifps_word_if.sv
// input channel: program words and start items
interface ifps_word_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] low_byte;
    logic [7:0] high_byte;
    logic       final_word;

    modport source (output valid, output mode, output low_byte, output high_byte,
                    output final_word, input ready);
    modport sink   (input valid, input mode, input low_byte, input high_byte,
                    input final_word, output ready);
endinterface

FILE: sv/ifps_frame_if.sv
// output channel: instruction frames
interface ifps_frame_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame;
    logic        wait_ready;
    logic        overflow;
    logic        end_of_run;

    modport source (output valid, output frame, output wait_ready, output overflow,
                    output end_of_run, input ready);
    modport sink   (input valid, input frame, input wait_ready, input overflow,
                    input end_of_run, output ready);
endinterface

FILE: sv/isp_flash_page_sequencer.sv
// top level of the isp flash page sequencer: config registers and unit wiring
// a word transfer is written into the command queue, then its first frame is loaded
//   into the output register and is valid from then on
// throughput: one frame per cycle while the receiver is ready; start and rejected words
//   give one frame, data words two, or three when the page write frame follows
// the rate is set by the single output register of the frame emitter
// reset: counters clear, page_shift returns to 5 and page_limit to 256
module isp_flash_page_sequencer
    import ifps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ifps_word_if.sink             words,
    ifps_frame_if.source          frames
);

    // configuration registers; the user must write them only while the block is idle, the block does not enforce it
    cfg_t      cfg_reg;

    // front to queue
    logic      push;
    cmd_t      push_cmd;

    // queue to back
    cmd_t      head;
    logic      pop;
    q_status_t q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.page_shift <= SHIFT_W'(5);
            cfg_reg.page_limit <= LIMIT_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PAGE_SHIFT: cfg_reg.page_shift <= cfg_data[SHIFT_W-1:0];
                REG_PAGE_LIMIT: cfg_reg.page_limit <= cfg_data[LIMIT_W-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front: takes each word transfer, updates word and page position,
    // and turns the word into one command for the back end
    ifps_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .words    (words),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // decoupling queue, lets the front keep taking words while frames drain
    ifps_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    // back: one frame per cycle into the output register while the receiver is ready, pops
    // the command with its last frame
    ifps_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .frames (frames)
    );

endmodule

FILE: sv/ifps_front.sv
// front end: accepts words, tracks page position and classifies each transfer
module ifps_front
    import ifps_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    ifps_word_if.sink       words,
    input  q_status_t       q_stat,
    output logic            push,
    output cmd_t            push_cmd
);

    logic [WIDX_W-1:0]    word_index_reg, word_index_next;
    logic [PAGE_W-1:0]    page_index_reg, page_index_next;
    logic                 overflowed_reg, overflowed_next;
    logic [PAGE_W-1:0]    limit;
    logic [WIDX_W-1:0]    widx_inc;
    logic [WIDX_W-1:0]    page_words;
    logic [ADDR_SPAN-1:0] addr_span;
    logic                 page_done;

    assign words.ready = !q_stat.full;
    assign push        = words.valid && !q_stat.full;

    always_comb
    begin
        limit      = (int'(cfg.page_limit) > MAX_PAGES) ? PAGE_W'(MAX_PAGES) : cfg.page_limit;
        widx_inc   = word_index_reg + WIDX_W'(1);
        page_words = WIDX_W'(1) << cfg.page_shift;
        page_done  = (widx_inc >= page_words) || words.final_word;
        addr_span  = ADDR_SPAN'(page_index_reg) << cfg.page_shift;

        word_index_next = word_index_reg;
        page_index_next = page_index_reg;
        overflowed_next = overflowed_reg;

        push_cmd.kind = CMD_ERASE;
        push_cmd.widx = word_index_reg;
        push_cmd.lo   = words.low_byte;
        push_cmd.hi   = words.high_byte;
        push_cmd.addr = addr_span[ADDR_W-1:0];

        if (!words.mode)
        begin
            word_index_next = '0;
            page_index_next = '0;
            overflowed_next = 1'b0;
        end
        else if (overflowed_reg || (page_index_reg >= limit))
        begin
            push_cmd.kind   = CMD_OVERFLOW;
            overflowed_next = 1'b1;
        end
        else if (page_done)
        begin
            push_cmd.kind   = CMD_LOAD_WRITE;
            word_index_next = '0;
            page_index_next = page_index_reg + PAGE_W'(1);
        end
        else
        begin
            push_cmd.kind   = CMD_LOAD;
            word_index_next = widx_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_index_reg <= '0;
            page_index_reg <= '0;
            overflowed_reg <= 1'b0;
        end
        else if (push)
        begin
            word_index_reg <= word_index_next;
            page_index_reg <= page_index_next;
            overflowed_reg <= overflowed_next;
        end
    end

    // page counter stops at the device size
    a_page_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(page_index_reg) <= MAX_PAGES)
        else $error("page index beyond device size");

endmodule

FILE: sv/ifps_cmd_queue.sv
// short command queue between front end and frame emitter
module ifps_cmd_queue
    import ifps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cmd_t       push_cmd,
    input  logic       pop,
    output cmd_t       head,
    output q_status_t  q_stat
);

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head         = mem[rd_ptr_reg];
    assign q_stat.full  = (int'(count_reg) == QDEPTH);
    assign q_stat.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("push into full command queue");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty command queue");

endmodule

FILE: sv/ifps_back.sv
// back end: expands queued commands into frames through the output register
module ifps_back
    import ifps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        head,
    input  q_status_t   q_stat,
    output logic        pop,
    ifps_frame_if.source frames
);

    typedef enum logic [1:0] {
        STEP_LOW,
        STEP_HIGH,
        STEP_WRITE
    } step_t;

    step_t       step_reg, step_next;
    logic        valid_reg, valid_next;
    logic [31:0] frame_reg, frame_next;
    logic        wait_reg, wait_next;
    logic        ovf_reg, ovf_next;
    logic        eor_reg, eor_next;
    logic        load;
    logic        take;

    assign frames.valid      = valid_reg;
    assign frames.frame      = frame_reg;
    assign frames.wait_ready = wait_reg;
    assign frames.overflow   = ovf_reg;
    assign frames.end_of_run = eor_reg;

    always_comb
    begin
        load = !valid_reg || frames.ready;
        take = load && !q_stat.empty;

        frame_next = '0;
        wait_next  = 1'b0;
        ovf_next   = 1'b0;
        eor_next   = 1'b1;

        case (head.kind)
            CMD_ERASE:
            begin
                frame_next = {OP_ERASE, OP_ERASE_ARG, 16'h0000};
            end
            CMD_OVERFLOW:
            begin
                ovf_next = 1'b1;
            end
            CMD_LOAD, CMD_LOAD_WRITE:
            begin
                case (step_reg)
                    STEP_LOW:
                    begin
                        frame_next = {OP_LOAD_LOW, 8'h00, head.widx, head.lo};
                        eor_next   = 1'b0;
                    end
                    STEP_HIGH:
                    begin
                        frame_next = {OP_LOAD_HIGH, 8'h00, head.widx, head.hi};
                        eor_next   = (head.kind == CMD_LOAD);
                    end
                    STEP_WRITE:
                    begin
                        frame_next = {OP_WRITE_PAGE, head.addr, 8'h00};
                        wait_next  = 1'b1;
                    end
                    default:
                    begin
                        frame_next = '0;
                    end
                endcase
            end
            default:
            begin
                frame_next = '0;
            end
        endcase

        pop = take && eor_next;

        step_next = step_reg;
        if (take)
        begin
            if (eor_next)
            begin
                step_next = STEP_LOW;
            end
            else if (step_reg == STEP_LOW)
            begin
                step_next = STEP_HIGH;
            end
            else
            begin
                step_next = STEP_WRITE;
            end
        end

        valid_next = load ? !q_stat.empty : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_LOW;
            valid_reg <= 1'b0;
            frame_reg <= '0;
            wait_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            eor_reg   <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
            if (take)
            begin
                frame_reg <= frame_next;
                wait_reg  <= wait_next;
                ovf_reg   <= ovf_next;
                eor_reg   <= eor_next;
            end
        end
    end

    a_ovf_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && ovf_reg) |-> (frame_reg == '0 && eor_reg && !wait_reg))
        else $error("overflow result carries a frame");

    a_poll_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && wait_reg) |-> (eor_reg && frame_reg[31:24] == OP_WRITE_PAGE))
        else $error("poll mark on a frame other than page write");

endmodule

FILE: tb/sv/isp_flash_page_sequencer_tb.sv
// self-checking testbench of the isp flash page sequencer: directed rows and random images
module isp_flash_page_sequencer_tb;
    import ifps_pkg::*;

    // input item codes
    localparam bit MODE_START = 1'b0;
    localparam bit MODE_WORD  = 1'b1;

    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 28;
    localparam int TAIL_CYCLES = 20;
    localparam int HOLD_CYCLES = 120;
    localparam int PRINT_CAP   = 100;

    // one input transfer
    typedef struct packed {
        logic       mode;
        logic [7:0] lo;
        logic [7:0] hi;
        logic       fin;
    } word_t;

    // one output transfer
    typedef struct packed {
        logic [31:0] frame;
        logic        wait_ready;
        logic        overflow;
        logic        end_of_run;
    } frame_t;

    // directed stimulus row: either a settings change or an input item,
    // optionally with its first frame written out by hand
    typedef struct packed {
        bit                 is_cfg;
        logic [SHIFT_W-1:0] pg_shift;
        logic [LIMIT_W-1:0] pg_limit;
        word_t              w;
        bit                 typed;
        frame_t             first;
    } stim_row_t;

    localparam frame_t ERASE_RESULT = '{frame: {OP_ERASE, OP_ERASE_ARG, 16'h0000},
                                        wait_ready: 1'b0, overflow: 1'b0, end_of_run: 1'b1};
    localparam frame_t REJECT_RESULT = '{frame: 32'h0000_0000,
                                         wait_ready: 1'b0, overflow: 1'b1, end_of_run: 1'b1};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ifps_word_if  words_ch ();
    ifps_frame_if frames_ch ();

    isp_flash_page_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .words     (words_ch),
        .frames    (frames_ch)
    );

    // sequencer state as the testbench sees it
    logic [WIDX_W-1:0]  word_slot;
    logic [PAGE_W-1:0]  page_num;
    logic               rejecting;
    logic [SHIFT_W-1:0] shift_cfg;
    logic [LIMIT_W-1:0] limit_cfg;

    frame_t step_frames [3];
    frame_t expected_frames [$];

    int  mismatches;
    int  frames_checked;
    int  page_writes_seen;
    int  rejects_seen;
    int  items_sent;
    int  settings_used;
    int  burst_left;
    bit  long_hold_req;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // prints one line per mismatch (up to a cap) and counts all of them
    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: %s wrong on frame %0d: got %h, want %h",
                     $time, field, frames_checked, got, want);
    endtask

    // frames caused by one input item; advances the tracked state
    function automatic int sequence_word(input word_t w);
        logic [ADDR_W-1:0] addr;
        int                eff_limit;
        if (w.mode == MODE_START)
        begin
            word_slot = '0;
            page_num  = '0;
            rejecting = 1'b0;
            step_frames[0] = ERASE_RESULT;
            return 1;
        end
        // page_limit above the device size is clamped
        eff_limit = (int'(limit_cfg) > MAX_PAGES) ? MAX_PAGES : int'(limit_cfg);
        if (rejecting || int'(page_num) >= eff_limit)
        begin
            // once rejected, every word is rejected until the next start
            rejecting = 1'b1;
            step_frames[0] = REJECT_RESULT;
            return 1;
        end
        step_frames[0] = '{frame: {OP_LOAD_LOW, 8'h00, word_slot, w.lo},
                           wait_ready: 1'b0, overflow: 1'b0, end_of_run: 1'b0};
        step_frames[1] = '{frame: {OP_LOAD_HIGH, 8'h00, word_slot, w.hi},
                           wait_ready: 1'b0, overflow: 1'b0, end_of_run: 1'b1};
        word_slot = word_slot + WIDX_W'(1);
        if (int'(word_slot) >= (1 << shift_cfg) || w.fin)
        begin
            // page write address keeps only its low 16 bits
            addr = ADDR_W'(32'(page_num) << shift_cfg);
            step_frames[1].end_of_run = 1'b0;
            step_frames[2] = '{frame: {OP_WRITE_PAGE, addr, 8'h00},
                               wait_ready: 1'b1, overflow: 1'b0, end_of_run: 1'b1};
            page_num  = page_num + PAGE_W'(1);
            word_slot = '0;
            return 3;
        end
        return 2;
    endfunction

    function automatic word_t rand_word(input bit mode);
        word_t w;
        w.mode = mode;
        w.lo   = 8'($urandom_range(0, 255));
        w.hi   = 8'($urandom_range(0, 255));
        w.fin  = ($urandom_range(0, 3) == 0);
        return w;
    endfunction

    function automatic stim_row_t item_row(input bit mode, input logic [7:0] lo,
                                           input logic [7:0] hi, input bit fin);
        stim_row_t r;
        r        = '0;
        r.w      = '{mode: mode, lo: lo, hi: hi, fin: fin};
        return r;
    endfunction

    function automatic stim_row_t checked_row(input bit mode, input logic [7:0] lo,
                                              input logic [7:0] hi, input bit fin,
                                              input frame_t first);
        stim_row_t r;
        r       = item_row(mode, lo, hi, fin);
        r.typed = 1'b1;
        r.first = first;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [SHIFT_W-1:0] pg_shift,
                                          input logic [LIMIT_W-1:0] pg_limit);
        stim_row_t r;
        r          = '0;
        r.is_cfg   = 1'b1;
        r.pg_shift = pg_shift;
        r.pg_limit = pg_limit;
        return r;
    endfunction

    // offer one item in the sender's burst pattern, predict it on transfer
    task automatic drive_word(input word_t w, input bit typed = 1'b0,
                              input frame_t first = '0);
        int gap;
        int n;
        if (burst_left == 0)
        begin
            // a quarter of the bursts follow on with no gap at all
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                words_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        words_ch.valid      <= 1'b1;
        words_ch.mode       <= w.mode;
        words_ch.low_byte   <= w.lo;
        words_ch.high_byte  <= w.hi;
        words_ch.final_word <= w.fin;
        // ready is read before this edge's updates land
        do @(posedge clk); while (!words_ch.ready);
        n = sequence_word(w);
        if (typed)
            step_frames[0] = first;
        for (int k = 0; k < n; k++)
            expected_frames.insert(expected_frames.size(), step_frames[k]);
        items_sent++;
    endtask

    // sender stops and waits for every outstanding frame
    task automatic pause_until_drained();
        words_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (expected_frames.size() != 0);
    endtask

    // writes both registers on back-to-back cycles; block must be idle
    task automatic set_page_config(input logic [SHIFT_W-1:0] pg_shift,
                                   input logic [LIMIT_W-1:0] pg_limit);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PAGE_SHIFT;
        cfg_data  <= CFG_DATA_W'(pg_shift);
        @(posedge clk);
        shift_cfg = pg_shift;
        cfg_index <= REG_PAGE_LIMIT;
        cfg_data  <= CFG_DATA_W'(pg_limit);
        @(posedge clk);
        limit_cfg = pg_limit;
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // frame receiver: changing stall styles, plus a long hold-off on request
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

    initial
    begin
        stall_style_t style;
        int           style_left;
        int           hold_left;
        int           tick;
        frames_ch.ready = 1'b0;
        style_left      = 0;
        hold_left       = 0;
        tick            = 0;
        style           = STALL_NONE;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            tick++;
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                // block fills up and must push back on its input
                hold_left--;
                frames_ch.ready <= 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style      = stall_style_t'($urandom_range(0, 3));
                    style_left = $urandom_range(20, 80);
                end
                style_left--;
                case (style)
                    STALL_NONE:     frames_ch.ready <= 1'b1;
                    STALL_LIGHT:    frames_ch.ready <= ($urandom_range(0, 3) != 0);
                    STALL_HEAVY:    frames_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:        frames_ch.ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    // frame checker: every transfer against the oldest prediction
    initial
    begin
        frame_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && frames_ch.valid && frames_ch.ready)
            begin
                if (expected_frames.size() == 0)
                    report_mismatch("unexpected frame", frames_ch.frame, 32'h0);
                else
                begin
                    want = expected_frames.pop_front();
                    if (frames_ch.frame !== want.frame)
                        report_mismatch("frame", frames_ch.frame, want.frame);
                    if (frames_ch.wait_ready !== want.wait_ready)
                        report_mismatch("wait_ready", 32'(frames_ch.wait_ready),
                                        32'(want.wait_ready));
                    if (frames_ch.overflow !== want.overflow)
                        report_mismatch("overflow", 32'(frames_ch.overflow),
                                        32'(want.overflow));
                    if (frames_ch.end_of_run !== want.end_of_run)
                        report_mismatch("end_of_run", 32'(frames_ch.end_of_run),
                                        32'(want.end_of_run));
                    if (want.wait_ready)
                        page_writes_seen++;
                    if (want.overflow)
                        rejects_seen++;
                    frames_checked++;
                end
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #8000000;
        $display("timeout with %0d frames outstanding", expected_frames.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        stim_row_t rows [$];
        word_t     w;
        int        phase_start;
        int        image_len;
        int        page_words;
        bit        hold_issued;
        bit        drain_issued;

        // every input known from time zero
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_PAGE_SHIFT;
        cfg_data            = '0;
        words_ch.valid      = 1'b0;
        words_ch.mode       = MODE_START;
        words_ch.low_byte   = 8'h00;
        words_ch.high_byte  = 8'h00;
        words_ch.final_word = 1'b0;
        mismatches          = 0;
        frames_checked      = 0;
        page_writes_seen    = 0;
        rejects_seen        = 0;
        items_sent          = 0;
        settings_used       = 1;
        burst_left          = 0;
        long_hold_req       = 1'b0;
        hold_issued         = 1'b0;
        drain_issued        = 1'b0;

        // state after reset: 32-word pages, 256 pages
        word_slot = '0;
        page_num  = '0;
        rejecting = 1'b0;
        shift_cfg = SHIFT_W'(5);
        limit_cfg = LIMIT_W'(256);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; the first group runs on the reset settings
        rows.insert(rows.size(), checked_row(MODE_START, 8'h00, 8'h00, 1'b0, ERASE_RESULT));
        rows.insert(rows.size(), checked_row(MODE_WORD, 8'h00, 8'hFF, 1'b0,
            '{frame: {OP_LOAD_LOW, 24'h00_0000}, wait_ready: 1'b0, overflow: 1'b0,
              end_of_run: 1'b0}));
        rows.insert(rows.size(), item_row(MODE_WORD, 8'hFF, 8'h00, 1'b0));
        // last word of a part-filled page
        rows.insert(rows.size(), item_row(MODE_WORD, 8'hA5, 8'h5A, 1'b1));
        // two-word pages, two pages
        rows.insert(rows.size(), cfg_row(SHIFT_W'(1), LIMIT_W'(2)));
        // start ignores the data fields
        rows.insert(rows.size(), checked_row(MODE_START, 8'hFF, 8'hFF, 1'b1, ERASE_RESULT));
        rows.insert(rows.size(), item_row(MODE_WORD, 8'h01, 8'h80, 1'b0));
        rows.insert(rows.size(), item_row(MODE_WORD, 8'h7F, 8'hFE, 1'b0));
        rows.insert(rows.size(), item_row(MODE_WORD, 8'hC3, 8'h3C, 1'b0));
        // last word that also fills the page: one page write only
        rows.insert(rows.size(), item_row(MODE_WORD, 8'h12, 8'h34, 1'b1));
        // page limit reached, then stays rejecting
        rows.insert(rows.size(), checked_row(MODE_WORD, 8'h00, 8'h00, 1'b0, REJECT_RESULT));
        rows.insert(rows.size(), checked_row(MODE_WORD, 8'hFF, 8'hFF, 1'b1, REJECT_RESULT));
        // start clears the rejection
        rows.insert(rows.size(), checked_row(MODE_START, 8'h00, 8'h00, 1'b0, ERASE_RESULT));
        rows.insert(rows.size(), item_row(MODE_WORD, 8'h0F, 8'hF0, 1'b1));
        // one-word pages with a zero page limit rejects everything
        rows.insert(rows.size(), cfg_row(SHIFT_W'(0), LIMIT_W'(0)));
        rows.insert(rows.size(), checked_row(MODE_START, 8'h00, 8'h00, 1'b0, ERASE_RESULT));
        rows.insert(rows.size(), checked_row(MODE_WORD, 8'h55, 8'hAA, 1'b0, REJECT_RESULT));
        // largest pages, page limit above the device size
        rows.insert(rows.size(), cfg_row(SHIFT_W'(7), LIMIT_W'(2047)));
        rows.insert(rows.size(), checked_row(MODE_START, 8'h00, 8'h00, 1'b0, ERASE_RESULT));
        rows.insert(rows.size(), item_row(MODE_WORD, 8'hFF, 8'hFF, 1'b1));
        rows.insert(rows.size(), item_row(MODE_WORD, 8'h11, 8'h22, 1'b1));
        rows.insert(rows.size(), item_row(MODE_WORD, 8'h80, 8'h01, 1'b0));
        rows.insert(rows.size(), item_row(MODE_WORD, 8'hFE, 8'h7F, 1'b1));

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                pause_until_drained();
                set_page_config(rows[i].pg_shift, rows[i].pg_limit);
            end
            else
                drive_word(rows[i].w, rows[i].typed, rows[i].first);
        end

        // random part: mostly whole images after a start, some loose items
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            pause_until_drained();
            case (phase)
                0:       set_page_config(SHIFT_W'(1), LIMIT_W'(3));
                1:       set_page_config(SHIFT_W'(7), LIMIT_W'(1024));
                2:       set_page_config(SHIFT_W'($urandom_range(0, 3)),
                                         LIMIT_W'($urandom_range(1, 6)));
                3:       set_page_config(SHIFT_W'($urandom_range(0, 7)),
                                         LIMIT_W'($urandom_range(0, 2047)));
                default: set_page_config(SHIFT_W'($urandom_range(0, 4)),
                                         LIMIT_W'($urandom_range(1, 10)));
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                // long receiver hold-off while the sender keeps offering
                if (phase == 1 && !hold_issued && items_sent - phase_start > 8)
                begin
                    long_hold_req = 1'b1;
                    hold_issued   = 1'b1;
                end
                // one mid-stream pause until the block has drained
                if (phase == 2 && !drain_issued && items_sent - phase_start > 15)
                begin
                    pause_until_drained();
                    drain_issued = 1'b1;
                end
                if ($urandom_range(0, 4) != 0)
                begin
                    page_words = 1 << shift_cfg;
                    if ($urandom_range(0, 5) == 0)
                        image_len = page_words + 1;
                    else
                        image_len = $urandom_range(1, (2 * page_words + 1 < 12) ?
                                                      2 * page_words + 1 : 12);
                    drive_word(rand_word(MODE_START));
                    for (int i = 1; i <= image_len; i++)
                    begin
                        w     = rand_word(MODE_WORD);
                        w.fin = (i == image_len) || ($urandom_range(0, 9) == 0);
                        drive_word(w);
                    end
                end
                else
                    drive_word(rand_word(($urandom_range(0, 3) != 0) ? MODE_WORD : MODE_START));
            end
        end

        pause_until_drained();
        // catch any stray frame after the last expected one
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d input transfers over %0d settings: %0d frames checked,",
                 items_sent, settings_used, frames_checked);
        $display("  %0d page writes and %0d rejected words among them",
                 page_writes_seen, rejects_seen);
        if (mismatches == 0 && expected_frames.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
